// ===== rtl/core/psc_pkg.sv =====
// psc_pkg.sv: widths, constants and shared types of the pressure sensor compensation block.
// No dependencies; every file of the block imports it.
package psc_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam int CAL_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CAL_IDX_ONE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_TWO   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_THREE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CAL_IDX_FOUR  = 8'd3;

    // Field widths
    localparam int RAW_W = 16;
    localparam int TT_W  = 12;   // temp_tenths
    localparam int PT_W  = 15;   // pressure_tenths_mbar
    localparam int DEG_W = 9;    // temp_degrees
    localparam int MM_W  = 11;   // pressure_mmhg

    // Internal value widths
    localparam int TF_W = 16;    // corrected temperature, before saturation
    localparam int PF_W = 22;    // corrected pressure, before saturation

    // First-order compensation
    localparam logic [16:0]        UT_BASE    = 17'd20224;
    localparam logic [16:0]        PRAW_BASE  = 17'd7168;
    localparam logic [15:0]        GAIN_BASE  = 16'd24576;
    localparam logic [9:0]         K4_BASE    = 10'd512;
    localparam logic [6:0]         K6_T_ADD   = 7'd50;
    localparam logic signed [15:0] T_LOW      = 16'sd200;
    localparam logic signed [15:0] T_HIGH     = 16'sd450;
    localparam logic signed [15:0] P_BASE     = 16'sd2500;
    localparam int                 TDT_SHIFT  = 10;
    localparam int                 OFFS_SHIFT = 12;
    localparam int                 GAIN_SHIFT = 10;
    localparam int                 X_SHIFT    = 14;
    localparam int                 P_SHIFT    = 5;

    // Second-order correction
    localparam logic [6:0]         K6_C_ADD    = 7'd24;
    localparam logic [3:0]         COLD_T_MUL  = 4'd11;
    localparam logic [3:0]         HOT_T_MUL   = 4'd3;
    localparam logic [1:0]         COLD_P_MUL  = 2'd3;
    localparam logic signed [15:0] COLD_P_REF  = 16'sd3500;
    localparam logic signed [15:0] HOT_P_REF   = 16'sd10000;
    localparam int                 T2_SHIFT    = 20;
    localparam int                 COLD_SHIFT  = 14;
    localparam int                 HOT_SHIFT   = 13;

    // Output ranges and unit conversion
    localparam logic signed [15:0] TEMP_MIN    = -16'sd1000;
    localparam logic signed [15:0] TEMP_MAX    = 16'sd2000;
    localparam logic [14:0]        PRES_MAX    = 15'd20000;
    localparam logic [16:0]        MMHG_NUM    = 17'd75006;
    localparam logic [19:0]        MMHG_DEN    = 20'd1000000;
    localparam logic [20:0]        MMHG_RECIP  = 21'd1258391;  // floor(2^24 * 0.075006)
    localparam int                 MMHG_SHIFT  = 24;
    localparam logic [10:0]        DEG_RECIP   = 11'd1639;     // 2^14 / 10, rounded up
    localparam int                 DEG_SHIFT   = 14;

    // Corrected values handed to the output conversion
    typedef struct packed {
        logic signed [TF_W-1:0] temp;
        logic signed [PF_W-1:0] pres;
    } psc_comp_t;

    // One result item, first field in the high bits
    typedef struct packed {
        logic [MM_W-1:0]         pressure_mmhg;
        logic signed [DEG_W-1:0] temp_degrees;
        logic [PT_W-1:0]         pressure_tenths_mbar;
        logic signed [TT_W-1:0]  temp_tenths;
    } psc_result_t;

endpackage

// ===== rtl/core/psc_out_conv.sv =====
// psc_out_conv.sv: saturation and unit conversion (tenths, whole degrees, mmHg).
// Four-stage pipeline with per-stage valid and ready; depends on psc_pkg.
module psc_out_conv
    import psc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  psc_comp_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output psc_result_t out_data
);

    localparam int NSTG   = 4;
    localparam int TMAG_W = TT_W - 1;
    localparam int MMA_W  = 35;
    localparam int MMN_W  = 31;
    localparam int DQP_W  = 22;
    localparam int DQ_W   = DEG_W - 1;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 1: saturate
    logic signed [TT_W-1:0] ts_next, ts1_reg;
    logic [PT_W-1:0]        ps_next, ps1_reg;

    always_comb
    begin
        priority if (in_data.temp < TF_W'(TEMP_MIN))
            ts_next = TT_W'(TEMP_MIN);
        else if (in_data.temp > TF_W'(TEMP_MAX))
            ts_next = TT_W'(TEMP_MAX);
        else
            ts_next = TT_W'(in_data.temp);

        priority if (in_data.pres[PF_W-1])
            ps_next = '0;
        else if (in_data.pres > $signed({7'b0, PRES_MAX}))
            ps_next = PRES_MAX;
        else
            ps_next = PT_W'(in_data.pres);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ts1_reg <= ts_next;
            ps1_reg <= ps_next;
        end
    end

    // Stage 2: magnitude of temperature, mmHg products
    logic [TMAG_W-1:0]      tmag_next, tmag2_reg;
    logic                   tneg2_reg;
    logic [MMA_W-1:0]       mma_next, mma2_reg;
    logic [MMN_W-1:0]       mmn_next, mmn2_reg;
    logic signed [TT_W-1:0] ts2_reg;
    logic [PT_W-1:0]        ps2_reg;

    always_comb
    begin
        tmag_next = ts1_reg[TT_W-1] ? TMAG_W'(-ts1_reg) : TMAG_W'(ts1_reg);
        mma_next  = MMA_W'(ps1_reg) * MMA_W'(MMHG_RECIP);
        mmn_next  = MMN_W'(ps1_reg) * MMN_W'(MMHG_NUM);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            tmag2_reg <= tmag_next;
            tneg2_reg <= ts1_reg[TT_W-1];
            mma2_reg  <= mma_next;
            mmn2_reg  <= mmn_next;
            ts2_reg   <= ts1_reg;
            ps2_reg   <= ps1_reg;
        end
    end

    // Stage 3: quotient estimates; mmHg estimate may be one low
    logic [MM_W-1:0]        q0_next, q03_reg;
    logic [MMN_W-1:0]       q0e_next, q0e3_reg;
    logic [DQP_W-1:0]       dqp;
    logic [DQ_W-1:0]        dq_next, dq3_reg;
    logic [MMN_W-1:0]       mmn3_reg;
    logic                   tneg3_reg;
    logic signed [TT_W-1:0] ts3_reg;
    logic [PT_W-1:0]        ps3_reg;

    always_comb
    begin
        q0_next  = MM_W'(mma2_reg >> MMHG_SHIFT);
        q0e_next = MMN_W'(q0_next) * MMN_W'(MMHG_DEN);
        dqp      = DQP_W'(tmag2_reg) * DQP_W'(DEG_RECIP);
        dq_next  = DQ_W'(dqp >> DEG_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            q03_reg   <= q0_next;
            q0e3_reg  <= q0e_next;
            dq3_reg   <= dq_next;
            mmn3_reg  <= mmn2_reg;
            tneg3_reg <= tneg2_reg;
            ts3_reg   <= ts2_reg;
            ps3_reg   <= ps2_reg;
        end
    end

    // Stage 4: mmHg correction, sign of whole degrees
    logic [MMN_W-1:0] rem;
    psc_result_t      result_next, result_reg;

    always_comb
    begin
        rem = mmn3_reg - q0e3_reg;
        result_next.temp_tenths          = ts3_reg;
        result_next.pressure_tenths_mbar = ps3_reg;
        result_next.temp_degrees         = tneg3_reg ? -$signed({1'b0, dq3_reg})
                                                     : $signed({1'b0, dq3_reg});
        result_next.pressure_mmhg        = (rem >= MMN_W'(MMHG_DEN)) ? q03_reg + 1'b1
                                                                     : q03_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            result_reg <= result_next;
        end
    end

    assign out_data = result_reg;

    // Checks
    logic signed [15:0] deg_err;
    assign deg_err = 16'(result_reg.temp_tenths) - 16'(result_reg.temp_degrees) * 16'sd10;

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_reg.temp_tenths >= TT_W'(TEMP_MIN))
                   && (result_reg.temp_tenths <= TT_W'(TEMP_MAX)))
        else $error("temp_tenths outside saturation range");

    a_deg_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (deg_err > -16'sd10) && (deg_err < 16'sd10))
        else $error("temp_degrees does not match temp_tenths");

    a_mmhg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_reg.pressure_tenths_mbar == '0) |-> result_reg.pressure_mmhg == '0)
        else $error("nonzero mmHg at zero pressure");

endmodule

// ===== rtl/core/pressure_sensor_compensation.sv =====
// Pressure and temperature compensation of a calibrated barometric sensor.
// Top level: calibration registers, nine compensation stages, output conversion
// (psc_out_conv). Depends on psc_pkg.
//
// Each item carries one raw pressure and one raw temperature conversion and
// yields one result item: temperature in 0.1 C, pressure in 0.1 mbar, whole
// degrees (truncated toward zero) and whole mmHg (truncated), each saturated
// to its range. The second-order correction is applied when the first-order
// temperature is below 20.0 C or above 45.0 C. Six coefficients are unpacked
// from four calibration words written on the cfg port (index 0..3, other
// indexes ignored); write them only while no item is in flight. The block
// takes one item per clock while m_tready does not hold results back, and
// passes each item through nine compensation stages (no stage chains two full
// multipliers; the three dt products sit side by side in stage 2) followed by
// four conversion stages. Every stage has its own valid bit and ready term,
// so bubbles collapse and input keeps flowing while a result waits on
// m_tready until all 13 stages are full.
module pressure_sensor_compensation
    import psc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // [15:0] pressure_raw, [31:16] temperature_raw
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,    // [11:0] temp_tenths, [26:12] pressure_tenths_mbar,
                                             // [35:27] temp_degrees, [46:36] pressure_mmhg
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CAL_W-1:0]     cfg_data
);

    localparam int NSTG   = 9;
    localparam int DT_W   = 18;
    localparam int M1_W   = 26;
    localparam int M2_W   = 29;
    localparam int T_W    = 15;
    localparam int OFFS_W = 17;
    localparam int GAIN_W = 18;
    localparam int GX_W   = 35;
    localparam int DM_W   = 13;
    localparam int XS_W   = 20;
    localparam int X10_W  = 24;
    localparam int P_W    = 19;
    localparam int DSQ_W  = 26;
    localparam int KC_W   = 10;
    localparam int TP_W   = 35;
    localparam int T2_W   = TP_W - T2_SHIFT;
    localparam int OPND_W = 16;
    localparam int PP_W   = 36;
    localparam int P2_W   = 21;

    // ------------------------------------------------------------------
    // Calibration words and coefficient unpacking
    // ------------------------------------------------------------------
    logic [CAL_W-1:0] cal_one_reg, cal_two_reg, cal_three_reg, cal_four_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_one_reg   <= '0;
            cal_two_reg   <= '0;
            cal_three_reg <= '0;
            cal_four_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CAL_IDX_ONE:   cal_one_reg   <= cfg_data;
                CAL_IDX_TWO:   cal_two_reg   <= cfg_data;
                CAL_IDX_THREE: cal_three_reg <= cfg_data;
                CAL_IDX_FOUR:  cal_four_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    logic [14:0] k1;
    logic [11:0] k2;
    logic [9:0]  k3;
    logic [9:0]  k4;
    logic [10:0] k5;
    logic [5:0]  k6;
    logic [16:0] ut;

    assign k1 = cal_one_reg[15:1];
    assign k2 = {cal_three_reg[5:0], cal_four_reg[5:0]};
    assign k3 = cal_four_reg[15:6];
    assign k4 = cal_three_reg[15:6];
    assign k5 = {cal_one_reg[0], cal_two_reg[15:6]};
    assign k6 = cal_two_reg[5:0];
    assign ut = {3'b000, k5, 3'b000} + UT_BASE;   // reference temperature count

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its item moves on
    // ------------------------------------------------------------------
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;
    logic            conv_ready;

    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || conv_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: temperature and pressure offsets
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]       pressure_raw, temperature_raw;
    logic signed [DT_W-1:0] dt_next, dt_reg;
    logic signed [DT_W-1:0] pd_next, pd1_reg;

    assign pressure_raw    = s_tdata[15:0];
    assign temperature_raw = s_tdata[31:16];
    assign dt_next = $signed({2'b00, temperature_raw}) - $signed({1'b0, ut});
    assign pd_next = $signed({2'b00, pressure_raw}) - $signed({1'b0, PRAW_BASE});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg  <= dt_next;
            pd1_reg <= pd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the three dt products
    // ------------------------------------------------------------------
    logic signed [7:0]      k6t;
    logic signed [10:0]     k4m;
    logic signed [10:0]     k3s;
    logic signed [M1_W-1:0] m1_next, m1_reg;
    logic signed [M2_W-1:0] m2_next, m2_reg;
    logic signed [M2_W-1:0] m3_next, m3_reg;
    logic signed [DT_W-1:0] pd2_reg;

    always_comb
    begin
        k6t     = $signed({2'b00, k6} + {1'b0, K6_T_ADD});
        k4m     = $signed({1'b0, k4}) - $signed({1'b0, K4_BASE});
        k3s     = $signed({1'b0, k3});
        m1_next = M1_W'(dt_reg) * M1_W'(k6t);
        m2_next = M2_W'(dt_reg) * M2_W'(k4m);
        m3_next = M2_W'(dt_reg) * M2_W'(k3s);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
            m3_reg  <= m3_next;
            pd2_reg <= pd1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first-order temperature, offset and gain
    // ------------------------------------------------------------------
    logic signed [T_W-1:0]    t_next, t3_reg;
    logic signed [OFFS_W-1:0] offs_next, offs3_reg;
    logic signed [GAIN_W-1:0] gain_next, gain3_reg;
    logic signed [DT_W-1:0]   pd3_reg;

    always_comb
    begin
        t_next    = T_W'(m1_reg >>> TDT_SHIFT) + T_W'(T_LOW);
        offs_next = $signed({3'b000, k2, 2'b00}) + OFFS_W'(m2_reg >>> OFFS_SHIFT);
        gain_next = $signed({3'b000, k1}) + GAIN_W'(m3_reg >>> GAIN_SHIFT)
                  + $signed(GAIN_W'(GAIN_BASE));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            t3_reg    <= t_next;
            offs3_reg <= offs_next;
            gain3_reg <= gain_next;
            pd3_reg   <= pd2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: gain product, range decision, distance from the bound
    // ------------------------------------------------------------------
    logic signed [GX_W-1:0]   gx_next, gx4_reg;
    logic                     cold_next, hot_next;
    logic [DM_W-1:0]          dm_next, dm4_reg;
    logic                     cold4_reg, hot4_reg;
    logic signed [T_W-1:0]    t4_reg;
    logic signed [OFFS_W-1:0] offs4_reg;

    always_comb
    begin
        gx_next   = GX_W'(gain3_reg) * GX_W'(pd3_reg);
        cold_next = t3_reg < T_W'(T_LOW);
        hot_next  = t3_reg > T_W'(T_HIGH);
        priority if (cold_next)
            dm_next = DM_W'(T_W'(T_LOW) - t3_reg);
        else if (hot_next)
            dm_next = DM_W'(t3_reg - T_W'(T_HIGH));
        else
            dm_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            gx4_reg   <= gx_next;
            dm4_reg   <= dm_next;
            cold4_reg <= cold_next;
            hot4_reg  <= hot_next;
            t4_reg    <= t3_reg;
            offs4_reg <= offs3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: first-order pressure, square of the distance
    // ------------------------------------------------------------------
    logic signed [XS_W-1:0]  xs;
    logic signed [X10_W-1:0] x10;
    logic signed [P_W-1:0]   p_next, p5_reg;
    logic [DSQ_W-1:0]        dsq_next, dsq5_reg;
    logic                    cold5_reg, hot5_reg;
    logic signed [T_W-1:0]   t5_reg;

    always_comb
    begin
        xs       = XS_W'(gx4_reg >>> X_SHIFT) - XS_W'(offs4_reg);
        x10      = (X10_W'(xs) <<< 3) + (X10_W'(xs) <<< 1);
        p_next   = P_W'(x10 >>> P_SHIFT) + P_W'(P_BASE);
        dsq_next = DSQ_W'(dm4_reg) * DSQ_W'(dm4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            p5_reg    <= p_next;
            dsq5_reg  <= dsq_next;
            cold5_reg <= cold4_reg;
            hot5_reg  <= hot4_reg;
            t5_reg    <= t4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: temperature correction product; zero factor mid-range
    // ------------------------------------------------------------------
    logic [6:0]            k6c;
    logic [KC_W-1:0]       kc;
    logic [TP_W-1:0]       tp_next, tp6_reg;
    logic signed [P_W-1:0] pdiff_next, pdiff6_reg;
    logic                  cold6_reg;
    logic signed [T_W-1:0] t6_reg;
    logic signed [P_W-1:0] p6_reg;

    always_comb
    begin
        k6c = {1'b0, k6} + K6_C_ADD;
        priority if (cold5_reg)
            kc = KC_W'(k6c) * KC_W'(COLD_T_MUL);
        else if (hot5_reg)
            kc = KC_W'(k6c) * KC_W'(HOT_T_MUL);
        else
            kc = '0;
        tp_next    = TP_W'(kc) * TP_W'(dsq5_reg);
        pdiff_next = cold5_reg ? (p5_reg - P_W'(COLD_P_REF)) : (p5_reg - P_W'(HOT_P_REF));
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            tp6_reg    <= tp_next;
            pdiff6_reg <= pdiff_next;
            cold6_reg  <= cold5_reg;
            t6_reg     <= t5_reg;
            p6_reg     <= p5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: t2 and the pressure correction factor
    // ------------------------------------------------------------------
    logic [T2_W-1:0]       t2_next, t27_reg;
    logic [OPND_W-1:0]     opnd_next, opnd7_reg;
    logic signed [P_W-1:0] pdiff7_reg;
    logic                  cold7_reg;
    logic signed [T_W-1:0] t7_reg;
    logic signed [P_W-1:0] p7_reg;

    always_comb
    begin
        t2_next   = T2_W'(tp6_reg >> T2_SHIFT);
        opnd_next = cold6_reg ? OPND_W'(t2_next) * OPND_W'(COLD_P_MUL) : OPND_W'(t2_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            t27_reg    <= t2_next;
            opnd7_reg  <= opnd_next;
            pdiff7_reg <= pdiff6_reg;
            cold7_reg  <= cold6_reg;
            t7_reg     <= t6_reg;
            p7_reg     <= p6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: pressure correction product
    // ------------------------------------------------------------------
    logic signed [PP_W-1:0] pp_next, pp8_reg;
    logic [T2_W-1:0]        t28_reg;
    logic                   cold8_reg;
    logic signed [T_W-1:0]  t8_reg;
    logic signed [P_W-1:0]  p8_reg;

    assign pp_next = PP_W'($signed({1'b0, opnd7_reg})) * PP_W'(pdiff7_reg);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            pp8_reg   <= pp_next;
            t28_reg   <= t27_reg;
            cold8_reg <= cold7_reg;
            t8_reg    <= t7_reg;
            p8_reg    <= p7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: apply both corrections
    // ------------------------------------------------------------------
    logic signed [P2_W-1:0] p2;
    psc_comp_t              comp_next, comp_reg;

    always_comb
    begin
        p2 = cold8_reg ? P2_W'(pp8_reg >>> COLD_SHIFT) : P2_W'(pp8_reg >>> HOT_SHIFT);
        comp_next.temp = TF_W'(t8_reg) - $signed({1'b0, t28_reg});
        comp_next.pres = PF_W'(p8_reg) - PF_W'(p2);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            comp_reg <= comp_next;
        end
    end

    // ------------------------------------------------------------------
    // Saturation and unit conversion
    // ------------------------------------------------------------------
    psc_result_t result;

    psc_out_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg[NSTG-1]),
        .in_ready  (conv_ready),
        .in_data   (comp_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {1'b0, result};

    // Checks
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> s_tready)
        else $error("input stalled with empty first stage");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted item not held in first stage");

    a_mid_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] && !cold4_reg && !hot4_reg |-> dm4_reg == '0)
        else $error("second-order distance nonzero in mid range");

endmodule
